[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
// Each check is sampled on the rising edge of clk and is switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, clocked on clk, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds, clocked on clk, disabled during reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/core/scp_pkg.sv]
package scp_pkg;

	// Fixed widths of the external fields.
	localparam int DATA_W        = 64;
	localparam int BYTE_W        = 8;
	localparam int SBOX_DEPTH    = 256;
	localparam int SRC_W         = 6;
	localparam int LANES         = 8;
	localparam int LANE_W        = 3;
	localparam int BLOCK_BYTES_D = 8;

	// Command codes carried by cmd.
	typedef enum logic [1:0] {
		CMD_SBOX = 2'd0,
		CMD_BMAP = 2'd1,
		CMD_ENC  = 2'd2
	} cmd_t;

	// Request to the S-box memory: a write or a read, never both.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} sbox_req_t;

	// Write of one bit map entry within a row.
	typedef struct packed {
		logic              we;
		logic [LANE_W-1:0] lane;
		logic [SRC_W-1:0]  data;
	} bm_wr_t;

	// One row of the bit map: eight source bit positions.
	typedef logic [LANES-1:0][SRC_W-1:0] bm_row_t;

endpackage

[rtl/core/scp_sbox.sv]
module scp_sbox (
	input  logic                          clk,
	input  scp_pkg::sbox_req_t            req,
	output logic [scp_pkg::BYTE_W-1:0]    rdata
);

	logic [scp_pkg::BYTE_W-1:0] mem [scp_pkg::SBOX_DEPTH];
	logic [scp_pkg::BYTE_W-1:0] rdata_q;

	// Single-port table: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/scp_bmap.sv]
module scp_bmap #(
	parameter int BLOCK_BYTES = scp_pkg::BLOCK_BYTES_D
) (
	input  logic                                     clk,
	input  scp_pkg::bm_wr_t                          wr,
	input  logic [((BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1)-1:0] wr_row,
	input  logic                                     re,
	input  logic [((BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1)-1:0] rd_row,
	output scp_pkg::bm_row_t                         rdata
);

	// One row per byte of the block, eight lanes per row, written one lane at a time.
	scp_pkg::bm_row_t mem [BLOCK_BYTES];
	scp_pkg::bm_row_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr_row][wr.lane] <= wr.data;
		end
		if (re) begin
			rdata_q <= mem[rd_row];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/scp_engine.sv]
module scp_engine #(
	parameter int BLOCK_BYTES = scp_pkg::BLOCK_BYTES_D
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Input channel
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [1:0]                               cmd,
	input  logic [scp_pkg::BYTE_W-1:0]               table_index,
	input  logic [scp_pkg::BYTE_W-1:0]               table_value,
	input  logic [8*BLOCK_BYTES-1:0]                 block_in,
	input  logic [8*BLOCK_BYTES-1:0]                 round_key,
	// S-box memory
	output scp_pkg::sbox_req_t                       sbox_req,
	input  logic [scp_pkg::BYTE_W-1:0]               sbox_rdata,
	// Bit map memory
	output scp_pkg::bm_wr_t                          bm_wr,
	output logic [((BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1)-1:0] bm_wr_row,
	output logic                                     bm_re,
	output logic [((BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1)-1:0] bm_rd_row,
	input  scp_pkg::bm_row_t                         bm_rdata,
	// Output channel
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [8*BLOCK_BYTES-1:0]                 out_block
);

	localparam int NBITS = 8 * BLOCK_BYTES;
	localparam int CNT_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
	localparam int BIT_W = $clog2(NBITS);
	localparam int BW    = scp_pkg::BYTE_W;
	localparam int SW    = scp_pkg::SRC_W;
	localparam int LW    = scp_pkg::LANE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_PERM,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    sub_rd_s1;
	logic                    perm_rd_s1;
	logic [CNT_W-1:0]        rd_idx_s1;
	logic [NBITS-1:0]        mixed_q;
	logic [NBITS-1:0]        sub_q;
	logic [NBITS-1:0]        perm_q;
	logic [NBITS-1:0]        out_q;
	logic                    out_valid_q;

	logic                    accept;
	logic                    last_cnt;
	logic [BW-1:0]           perm_bits;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign last_cnt = (cnt_q == CNT_W'(BLOCK_BYTES - 1));

	// S-box port: loads write while idle, substitution reads one byte a cycle.
	always_comb begin
		sbox_req       = '0;
		sbox_req.addr  = table_index;
		sbox_req.wdata = table_value;
		sbox_req.we    = accept && (cmd == scp_pkg::CMD_SBOX);
		if (state_q == ST_SUB) begin
			sbox_req.re   = 1'b1;
			sbox_req.addr = mixed_q[BW*cnt_q +: BW];
		end
	end

	// Bit map port: entries beyond the block are dropped, rows are read during permutation.
	always_comb begin
		bm_wr.we   = accept && (cmd == scp_pkg::CMD_BMAP)
			&& ({1'b0, table_index} < 9'(NBITS));
		bm_wr.lane = table_index[LW-1:0];
		bm_wr.data = table_value[SW-1:0];
		bm_wr_row  = table_index[LW +: CNT_W];
		bm_re      = (state_q == ST_PERM);
		bm_rd_row  = cnt_q;
	end

	// Eight output bits from one bit map row; a source beyond the block gives zero.
	always_comb begin
		for (int j = 0; j < scp_pkg::LANES; j++) begin
			perm_bits[j] = ({1'b0, bm_rdata[j]} < 7'(NBITS))
				? sub_q[bm_rdata[j][BIT_W-1:0]] : 1'b0;
		end
	end

	// Sequencer with the block registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sub_rd_s1   <= 1'b0;
			perm_rd_s1  <= 1'b0;
			rd_idx_s1   <= '0;
			mixed_q     <= '0;
			sub_q       <= '0;
			perm_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			sub_rd_s1  <= (state_q == ST_SUB);
			perm_rd_s1 <= (state_q == ST_PERM);
			rd_idx_s1  <= cnt_q;

			// Returning read data arrives in the cycle after its address and is stored at the delayed index.
			if (sub_rd_s1) begin
				sub_q[BW*rd_idx_s1 +: BW] <= sbox_rdata;
			end
			if (perm_rd_s1) begin
				perm_q[BW*rd_idx_s1 +: BW] <= perm_bits;
			end

			// The output register takes a finished block, or empties once its item is taken.
			if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && (cmd == scp_pkg::CMD_ENC)) begin
						mixed_q <= block_in ^ round_key;
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					cnt_q <= last_cnt ? '0 : cnt_q + 1'b1;
					if (last_cnt) begin
						state_q <= ST_PERM;
					end
				end
				ST_PERM: begin
					cnt_q <= last_cnt ? '0 : cnt_q + 1'b1;
					if (last_cnt) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q   <= perm_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_block = out_q;

endmodule

[rtl/core/spn_cipher_round.sv]
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------------
// input    | in_valid / in_ready       | cmd, table_index, table_value, block_in
// output   | out_valid / out_ready     | block_out
// config   | cfg_we (no wait)          | cfg_wdata (round key)
//
// A load item leaves the input open; the S-box or bit map write happens on acceptance.
// An encrypt item closes the input while the engine runs one S-box read per byte, then
// one bit map row read per byte, then a drain state and a final state, so the next
// encrypt item is taken only after the current round has handed its result on.
// The result sits in an output register, so the next item is taken while it waits.
// A stalled output only holds the engine in its final state until the register frees.
// Reset clears the control state and the round key; the tables are undefined until loaded.
`include "assert_macros.svh"

module spn_cipher_round #(
	parameter int BLOCK_BYTES = scp_pkg::BLOCK_BYTES_D
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [scp_pkg::DATA_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic [scp_pkg::BYTE_W-1:0]        table_index,
	input  logic [scp_pkg::BYTE_W-1:0]        table_value,
	input  logic [scp_pkg::DATA_W-1:0]        block_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [scp_pkg::DATA_W-1:0]        block_out
);

	localparam int NBITS = 8 * BLOCK_BYTES;
	localparam int CNT_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
	localparam int DW    = scp_pkg::DATA_W;

	logic [NBITS-1:0]             key_q;
	logic [NBITS-1:0]             out_block;
	scp_pkg::sbox_req_t           sbox_req;
	logic [scp_pkg::BYTE_W-1:0]   sbox_rdata;
	scp_pkg::bm_wr_t              bm_wr;
	logic [CNT_W-1:0]             bm_wr_row;
	logic                         bm_re;
	logic [CNT_W-1:0]             bm_rd_row;
	scp_pkg::bm_row_t             bm_rdata;

	// Round key; only the bits inside the block are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q <= cfg_wdata[NBITS-1:0];
		end
	end

	scp_sbox u_sbox (
		.clk   (clk),
		.req   (sbox_req),
		.rdata (sbox_rdata)
	);

	scp_bmap #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_bmap (
		.clk    (clk),
		.wr     (bm_wr),
		.wr_row (bm_wr_row),
		.re     (bm_re),
		.rd_row (bm_rd_row),
		.rdata  (bm_rdata)
	);

	scp_engine #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.table_index (table_index),
		.table_value (table_value),
		.block_in    (block_in[NBITS-1:0]),
		.round_key   (key_q),
		.sbox_req    (sbox_req),
		.sbox_rdata  (sbox_rdata),
		.bm_wr       (bm_wr),
		.bm_wr_row   (bm_wr_row),
		.bm_re       (bm_re),
		.bm_rd_row   (bm_rd_row),
		.bm_rdata    (bm_rdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_block   (out_block)
	);

	// Bits above the block read as zero.
	assign block_out = DW'(out_block);

	// An accepted encrypt item closes the input while the round runs.
	`ASSERT_CLK(a_enc_busy, (in_valid && in_ready && (cmd == scp_pkg::CMD_ENC)) |=> !in_ready, "input open after encrypt item")
	// Load items and unused codes never stall the input.
	`ASSERT_CLK(a_load_free, (in_valid && in_ready && (cmd != scp_pkg::CMD_ENC)) |=> in_ready, "input closed after load item")
	// A fresh result only appears at the end of a round, while the input is closed.
	`ASSERT_CLK(a_result_src, $rose(out_valid) |-> $past(!in_ready), "result without a finished round")

endmodule
